>>> rtl/tabs_pkg.sv
package tabs_pkg;

    localparam int COORD_BITS = 24;
    localparam int COUNT_BITS = 32;
    localparam int AREA_BITS  = 50;
    localparam int SUM_BITS   = 64;
    localparam int LIMIT_BITS = 20;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int CROSS_BITS = 2 * DIFF_BITS + 1;
    localparam int MAG_BITS   = CROSS_BITS - 1;
    localparam int RAD_BITS   = 2 * MAG_BITS + 2;
    localparam int ROOT_BITS  = RAD_BITS / 2;
    localparam int RCNT_BITS  = $clog2(ROOT_BITS + 1);
    localparam int MCNT_BITS  = $clog2(DIFF_BITS + 1);
    localparam int SQCNT_BITS = $clog2(MAG_BITS + 1);

    localparam int IN_BITS  = 9 * COORD_BITS;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS = 6 * COORD_BITS + SUM_BITS + 2 * AREA_BITS + 3 * COUNT_BITS;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef enum logic [1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_FINISH   = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQ,
        ST_ROOT,
        ST_ACC,
        ST_OUT
    } state_t;

endpackage

>>> rtl/tabs_serial_mul.sv
// Shift-and-add signed multiplier: one multiplier bit per cycle.
module tabs_serial_mul
    import tabs_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [DIFF_BITS-1:0]   op_a,
    input  logic signed [DIFF_BITS-1:0]   op_b,
    output logic                          done,
    output logic signed [2*DIFF_BITS-1:0] product
);

    logic [MCNT_BITS-1:0]          cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic signed [2*DIFF_BITS-1:0] acc_reg, acc_next;
    logic signed [2*DIFF_BITS-1:0] mcand_reg, mcand_next;
    logic [DIFF_BITS-1:0]          mplier_reg, mplier_next;

    // Next values of the shift-add loop; the sign bit of the multiplier weighs negative.
    always_comb
    begin
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = (2*DIFF_BITS)'(op_a);
            mplier_next = op_b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                if (cnt_reg == MCNT_BITS'(DIFF_BITS - 1))
                    acc_next = acc_reg - mcand_reg;
                else
                    acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MCNT_BITS'(DIFF_BITS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = busy_reg && (cnt_reg == MCNT_BITS'(DIFF_BITS - 1));
    assign product = acc_next;

endmodule

>>> rtl/tabs_root.sv
// Restoring square root, one result bit per cycle.
module tabs_root
    import tabs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_BITS-1:0]  radicand,
    output logic                 done,
    output logic [ROOT_BITS-1:0] root
);

    logic [RCNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [RAD_BITS-1:0]   rad_reg, rad_next;
    logic [ROOT_BITS+1:0]  rem_reg, rem_next;
    logic [ROOT_BITS-1:0]  q_reg, q_next;
    logic [ROOT_BITS+1:0]  trial;
    logic [ROOT_BITS+1:0]  cand;

    // Bring down two radicand bits and try the next root bit.
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        trial     = {rem_reg[ROOT_BITS-1:0], rad_reg[RAD_BITS-1 -: 2]};
        cand      = {q_reg, 2'b01};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            if (trial >= cand)
            begin
                rem_next = trial - cand;
                q_next   = {q_reg[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[ROOT_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == RCNT_BITS'(ROOT_BITS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = busy_reg && (cnt_reg == RCNT_BITS'(ROOT_BITS - 1));
    assign root = q_next;

endmodule

>>> rtl/triangle_area_bounds_stats.sv
// Channel | Dir | Handshake           | Contents
// s_axis  | in  | s_axis_tvalid/ready | tuser kind, tdata nine coordinates
// m_axis  | out | m_axis_tvalid/ready | tdata bounds, areas and counts
// cfg     | in  | cfg_we              | degenerate_limit
// A vertex or an unused kind is taken in the idle state, which it leaves as it was; a finish
// item moves to the output state and waits there until the result is taken. A triangle runs,
// from its accept to the next, through six serial products (a start and 25 bit steps each),
// three squarings (a load, a shift-add step per magnitude bit and an add each), the root
// start, the root at one bit per step, the accumulate state and the idle state that takes the next item.
// Reset is asynchronous and clears all statistics; the output holds until taken.
module triangle_area_bounds_stats
    import tabs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [8*IN_BYTES-1:0]  s_axis_tdata,  // ax ay az bx by bz cx cy cz
    input  logic [1:0]             s_axis_tuser,  // kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [8*OUT_BYTES-1:0] m_axis_tdata,  // min xyz, max xyz, total, least,
                                                  // greatest, vertices, triangles, degenerate
    input  logic                   cfg_we,
    input  logic [LIMIT_BITS-1:0]  cfg_data
);

    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [AREA_BITS-1:0]  AMAX = '1;
    localparam logic [COUNT_BITS-1:0] NMAX = '1;

    state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;

    logic signed [COORD_BITS-1:0] lo_reg [3];
    logic signed [COORD_BITS-1:0] hi_reg [3];
    logic [SUM_BITS-1:0]   sum_reg;
    logic [AREA_BITS-1:0]  least_reg, great_reg;
    logic [COUNT_BITS-1:0] vcnt_reg, tcnt_reg, dcnt_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [8*OUT_BYTES-1:0] out_reg, out_next;

    logic signed [DIFF_BITS-1:0] u_reg [3];
    logic signed [DIFF_BITS-1:0] v_reg [3];
    logic signed [CROSS_BITS-1:0] cr_reg [3];
    logic signed [2*DIFF_BITS-1:0] p1_reg;
    logic [RAD_BITS-1:0] rad_reg;
    logic [AREA_BITS-1:0] area_reg;

    // Squaring is shift-add on the magnitude, one bit per cycle.
    logic [MAG_BITS-1:0]   sq_m_reg;
    logic [RAD_BITS-1:0]   sq_acc_reg, sq_sh_reg;
    logic [SQCNT_BITS-1:0] sq_cnt_reg;

    logic signed [COORD_BITS-1:0] in_c [9];
    logic in_fire, out_fire;
    logic mul_start, mul_done, root_start, root_done;
    logic signed [DIFF_BITS-1:0] mul_a, mul_b;
    logic signed [2*DIFF_BITS-1:0] mul_p;
    logic [ROOT_BITS-1:0] root_q;
    logic [ROOT_BITS-1:0] half;
    logic [SUM_BITS:0] sum_wide;
    logic signed [CROSS_BITS-1:0] cr_sel;
    logic p1_phase_reg, p1_phase_next;
    logic mul_go_reg, mul_go_next;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            in_c[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;

    // Product pairs for the cross product: step k forms u[k+1]v[k+2], then u[k+2]v[k+1].
    always_comb
    begin
        logic [1:0] i1, i2;
        i1 = (step_reg == 2'd2) ? 2'd0 : step_reg + 2'd1;
        i2 = (step_reg == 2'd0) ? 2'd2 : step_reg - 2'd1;
        if (step_reg == 2'd1)
            i2 = 2'd0;
        if (step_reg == 2'd2)
            i2 = 2'd1;
        if (step_reg == 2'd0)
        begin
            i1 = 2'd1;
            i2 = 2'd2;
        end
        if (p1_phase_reg)
        begin
            mul_a = u_reg[i2];
            mul_b = v_reg[i1];
        end
        else
        begin
            mul_a = u_reg[i1];
            mul_b = v_reg[i2];
        end
    end

    assign mul_start = mul_go_reg;

    tabs_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign root_start = (state_reg == ST_SQ) && (step_reg == 2'd3);
    tabs_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (rad_reg),
        .done     (root_done),
        .root     (root_q)
    );

    assign half = {1'b0, root_q[ROOT_BITS-1:1]};
    assign cr_sel = cr_reg[step_reg];

    // Next state.
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        p1_phase_next = p1_phase_reg;
        mul_go_next   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && s_axis_tuser == KIND_TRIANGLE)
                begin
                    state_next    = ST_MUL;
                    step_next     = 2'd0;
                    p1_phase_next = 1'b0;
                    mul_go_next   = 1'b1;
                end
                else if (in_fire && s_axis_tuser == KIND_FINISH)
                    state_next = ST_OUT;
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (!p1_phase_reg)
                    begin
                        p1_phase_next = 1'b1;
                        mul_go_next   = 1'b1;
                    end
                    else if (step_reg == 2'd2)
                    begin
                        state_next = ST_SQ;
                        step_next  = 2'd0;
                        p1_phase_next = 1'b0;
                    end
                    else
                    begin
                        step_next     = step_reg + 2'd1;
                        p1_phase_next = 1'b0;
                        mul_go_next   = 1'b1;
                    end
                end
            end
            ST_SQ:
            begin
                if (step_reg == 2'd3)
                    state_next = ST_ROOT;
                else if (p1_phase_reg && sq_cnt_reg == SQCNT_BITS'(MAG_BITS))
                begin
                    step_next     = step_reg + 2'd1;
                    p1_phase_next = 1'b0;
                end
                else if (!p1_phase_reg)
                    p1_phase_next = 1'b1;
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_ACC;
            end
            ST_ACC:
                state_next = ST_IDLE;
            ST_OUT:
            begin
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            p1_phase_reg <= 1'b0;
            mul_go_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            p1_phase_reg <= p1_phase_next;
            mul_go_reg   <= mul_go_next;
        end
    end

    // Datapath for differences, cross terms, squares and the root.
    always_ff @(posedge clk)
    begin
        if (in_fire && s_axis_tuser == KIND_TRIANGLE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= DIFF_BITS'(in_c[3+i]) - DIFF_BITS'(in_c[i]);
                v_reg[i] <= DIFF_BITS'(in_c[6+i]) - DIFF_BITS'(in_c[i]);
            end
        end
        if (state_reg == ST_MUL && mul_done)
        begin
            if (!p1_phase_reg)
                p1_reg <= mul_p;
            else
                cr_reg[step_reg] <= CROSS_BITS'(p1_reg) - CROSS_BITS'(mul_p);
        end
        if (state_reg == ST_MUL && state_next == ST_SQ)
            rad_reg <= '0;
        if (state_reg == ST_SQ && step_reg != 2'd3)
        begin
            if (!p1_phase_reg)
            begin
                sq_m_reg   <= cr_sel[CROSS_BITS-1] ? MAG_BITS'(-cr_sel) : MAG_BITS'(cr_sel);
                sq_sh_reg  <= cr_sel[CROSS_BITS-1] ? RAD_BITS'(MAG_BITS'(-cr_sel))
                                                   : RAD_BITS'(MAG_BITS'(cr_sel));
                sq_acc_reg <= '0;
                sq_cnt_reg <= '0;
            end
            else if (sq_cnt_reg == SQCNT_BITS'(MAG_BITS))
                rad_reg <= rad_reg + sq_acc_reg;
            else
            begin
                if (sq_m_reg[0])
                    sq_acc_reg <= sq_acc_reg + sq_sh_reg;
                sq_m_reg   <= sq_m_reg >> 1;
                sq_sh_reg  <= sq_sh_reg << 1;
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
        end
        if (root_done)
            area_reg <= (half > ROOT_BITS'(AMAX)) ? AMAX : half[AREA_BITS-1:0];
    end

    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS+1)'(area_reg);

    // Statistics registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i] <= CMAX;
                hi_reg[i] <= CMIN;
            end
            sum_reg   <= '0;
            least_reg <= AMAX;
            great_reg <= '0;
            vcnt_reg  <= '0;
            tcnt_reg  <= '0;
            dcnt_reg  <= '0;
            limit_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_data;
            if (in_fire && s_axis_tuser == KIND_VERTEX)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (in_c[i] < lo_reg[i])
                        lo_reg[i] <= in_c[i];
                    if (in_c[i] > hi_reg[i])
                        hi_reg[i] <= in_c[i];
                end
                if (vcnt_reg != NMAX)
                    vcnt_reg <= vcnt_reg + 1'b1;
            end
            if (state_reg == ST_ACC)
            begin
                if (tcnt_reg != NMAX)
                    tcnt_reg <= tcnt_reg + 1'b1;
                sum_reg <= sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
                if (area_reg < least_reg)
                    least_reg <= area_reg;
                if (area_reg > great_reg)
                    great_reg <= area_reg;
                if (area_reg <= AREA_BITS'(limit_reg) && dcnt_reg != NMAX)
                    dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (in_fire && s_axis_tuser == KIND_FINISH)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lo_reg[i] <= CMAX;
                    hi_reg[i] <= CMIN;
                end
                sum_reg   <= '0;
                least_reg <= AMAX;
                great_reg <= '0;
                vcnt_reg  <= '0;
                tcnt_reg  <= '0;
                dcnt_reg  <= '0;
            end
        end
    end

    // Result item assembled from the current statistics.
    always_comb
    begin
        out_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            out_next[i*COORD_BITS +: COORD_BITS] = (vcnt_reg == '0) ? '0 : lo_reg[i];
            out_next[(3+i)*COORD_BITS +: COORD_BITS] = (vcnt_reg == '0) ? '0 : hi_reg[i];
        end
        out_next[6*COORD_BITS +: SUM_BITS] = sum_reg;
        out_next[6*COORD_BITS+SUM_BITS +: AREA_BITS] = (tcnt_reg == '0) ? '0 : least_reg;
        out_next[6*COORD_BITS+SUM_BITS+AREA_BITS +: AREA_BITS] = great_reg;
        out_next[6*COORD_BITS+SUM_BITS+2*AREA_BITS +: COUNT_BITS] = vcnt_reg;
        out_next[6*COORD_BITS+SUM_BITS+2*AREA_BITS+COUNT_BITS +: COUNT_BITS] = tcnt_reg;
        out_next[6*COORD_BITS+SUM_BITS+2*AREA_BITS+2*COUNT_BITS +: COUNT_BITS] = dcnt_reg;
    end

    // Result item captured on finish.
    always_ff @(posedge clk)
    begin
        if (in_fire && s_axis_tuser == KIND_FINISH)
            out_reg <= out_next;
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tabs_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t                box_min [3];
        coord_t                box_max [3];
        logic [SUM_BITS-1:0]   total;
        logic [AREA_BITS-1:0]  least;
        logic [AREA_BITS-1:0]  greatest;
        logic [COUNT_BITS-1:0] vertices;
        logic [COUNT_BITS-1:0] triangles;
        logic [COUNT_BITS-1:0] degenerates;
    } mesh_stats_t;

    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 5000;
    localparam logic [AREA_BITS-1:0]  AREA_FULL  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;
    localparam coord_t COORD_HIGH = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_LOW  = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [8*IN_BYTES-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [8*OUT_BYTES-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [LIMIT_BITS-1:0]  cfg_data;

    // Shadow of the block's statistics and register.
    coord_t                track_min [3];
    coord_t                track_max [3];
    logic [SUM_BITS-1:0]   area_total;
    logic [AREA_BITS-1:0]  area_low;
    logic [AREA_BITS-1:0]  area_high;
    logic [COUNT_BITS-1:0] seen_vertices;
    logic [COUNT_BITS-1:0] seen_triangles;
    logic [COUNT_BITS-1:0] seen_degenerates;
    logic [LIMIT_BITS-1:0] degenerate_limit;

    mesh_stats_t expected_stats [$];

    int error_count;
    int items_sent;
    int reports_seen;
    int limit_writes;
    int idle_cycles;
    int recv_hold;
    int recv_stall;
    bit no_gaps;

    triangle_area_bounds_stats i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic void clear_stats();
        for (int i = 0; i < 3; i++)
        begin
            track_min[i] = COORD_HIGH;
            track_max[i] = COORD_LOW;
        end
        area_total       = '0;
        area_low         = AREA_FULL;
        area_high        = '0;
        seen_vertices    = '0;
        seen_triangles   = '0;
        seen_degenerates = '0;
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] c);
        return (c == COUNT_FULL) ? c : c + 1'b1;
    endfunction

    // Area as half the truncated root of the squared cross-product length.
    function automatic logic [AREA_BITS-1:0] triangle_area(coord_t p [9]);
        longint      u [3];
        longint      v [3];
        longint      cr [3];
        logic [63:0]  mag;
        logic [127:0] radicand;
        logic [127:0] cand_sq;
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [63:0]  half;
        radicand = '0;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = longint'(p[3+i]) - longint'(p[i]);
            v[i] = longint'(p[6+i]) - longint'(p[i]);
        end
        cr[0] = u[1] * v[2] - u[2] * v[1];
        cr[1] = u[2] * v[0] - u[0] * v[2];
        cr[2] = u[0] * v[1] - u[1] * v[0];
        for (int i = 0; i < 3; i++)
        begin
            mag = (cr[i] < 0) ? 64'(-cr[i]) : 64'(cr[i]);
            radicand = radicand + {64'b0, mag} * {64'b0, mag};
        end
        root = '0;
        for (int b = 62; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            cand_sq = {64'b0, cand} * {64'b0, cand};
            if (cand_sq <= radicand)
                root = cand;
        end
        half = root >> 1;
        return (half > 64'(AREA_FULL)) ? AREA_FULL : half[AREA_BITS-1:0];
    endfunction

    // Applies one accepted item to the shadow state.
    function automatic void account_item(kind_t kind, coord_t p [9]);
        logic [AREA_BITS-1:0] area;
        logic [SUM_BITS:0]    sum;
        mesh_stats_t          s;
        case (kind)
            KIND_VERTEX:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (p[i] < track_min[i]) track_min[i] = p[i];
                    if (p[i] > track_max[i]) track_max[i] = p[i];
                end
                seen_vertices = bump(seen_vertices);
            end
            KIND_TRIANGLE:
            begin
                area = triangle_area(p);
                seen_triangles = bump(seen_triangles);
                sum = {1'b0, area_total} + area;
                area_total = sum[SUM_BITS] ? '1 : sum[SUM_BITS-1:0];
                if (area < area_low)  area_low  = area;
                if (area > area_high) area_high = area;
                if (area <= 50'(degenerate_limit))
                    seen_degenerates = bump(seen_degenerates);
            end
            KIND_FINISH:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s.box_min[i] = (seen_vertices == 0) ? '0 : track_min[i];
                    s.box_max[i] = (seen_vertices == 0) ? '0 : track_max[i];
                end
                s.total       = area_total;
                s.least       = (seen_triangles == 0) ? '0 : area_low;
                s.greatest    = area_high;
                s.vertices    = seen_vertices;
                s.triangles   = seen_triangles;
                s.degenerates = seen_degenerates;
                expected_stats = {expected_stats, s};
                clear_stats();
            end
            default:
            begin
                // An unused kind leaves everything as it was.
            end
        endcase
    endfunction

    // Sends one item after a random gap and waits until the block takes it.
    task automatic send_item(kind_t kind, coord_t p [9]);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {p[8], p[7], p[6], p[5], p[4], p[3], p[2], p[1], p[0]};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        account_item(kind, p);
        items_sent++;
    endtask

    task automatic send_vertex(coord_t x, coord_t y, coord_t z);
        coord_t p [9];
        foreach (p[i]) p[i] = coord_t'($urandom());
        p[0] = x;
        p[1] = y;
        p[2] = z;
        send_item(KIND_VERTEX, p);
    endtask

    task automatic send_kind(kind_t kind);
        coord_t p [9];
        foreach (p[i]) p[i] = coord_t'($urandom());
        send_item(kind, p);
    endtask

    // Waits until every report is in and the block has settled, then writes the limit.
    task automatic write_limit(logic [LIMIT_BITS-1:0] value);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_stats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        degenerate_limit = value;
        limit_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic coord_t random_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_HIGH;
            1:       return COORD_LOW;
            2:       return '0;
            default: return coord_t'($urandom());
        endcase
    endfunction

    // Random triangle: local, full range, collinear, coincident, tiny or extreme.
    function automatic void make_triangle(output coord_t p [9]);
        int     mode;
        int     span;
        longint d;
        mode = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 4096 : 16;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = coord_t'($urandom_range(0, 2 * 8380000)) - coord_t'(8380000);
            d = longint'($urandom_range(0, 2 * 1000)) - 1000;
            case (mode)
                0, 1, 2, 3:
                begin
                    p[3+i] = p[i] + coord_t'(longint'($urandom_range(0, 2 * span)) - span);
                    p[6+i] = p[i] + coord_t'(longint'($urandom_range(0, 2 * span)) - span);
                end
                4, 5:
                begin
                    p[i]   = coord_t'($urandom());
                    p[3+i] = coord_t'($urandom());
                    p[6+i] = coord_t'($urandom());
                end
                6:
                begin
                    p[3+i] = p[i] + coord_t'(d);
                    p[6+i] = p[i] - coord_t'(2 * d);
                end
                7:
                begin
                    p[3+i] = p[i];
                    p[6+i] = p[i];
                end
                8:
                begin
                    p[3+i] = p[i] + coord_t'((i == 0) ? 1 : 0);
                    p[6+i] = p[i] + coord_t'((i == 1) ? 1 : 0);
                end
                default:
                begin
                    p[i]   = random_coord();
                    p[3+i] = random_coord();
                    p[6+i] = random_coord();
                end
            endcase
        end
    endfunction

    task automatic send_triangle();
        coord_t p [9];
        make_triangle(p);
        send_item(KIND_TRIANGLE, p);
    endtask

    task automatic send_corners(coord_t a, coord_t b, coord_t c);
        coord_t p [9];
        p = '{a, a, a, b, b, b, c, c, c};
        send_item(KIND_TRIANGLE, p);
    endtask

    // A mesh with no geometry and one with only unused kinds.
    task automatic test_empty_mesh();
        send_kind(KIND_FINISH);
        send_kind(KIND_UNUSED);
        send_kind(KIND_UNUSED);
        send_kind(KIND_FINISH);
    endtask

    // Extreme coordinates for the box and the largest triangles.
    task automatic test_extremes();
        coord_t p [9];
        send_vertex(COORD_HIGH, COORD_LOW, '0);
        send_vertex(COORD_LOW, COORD_HIGH, coord_t'(-1));
        send_vertex('0, '0, COORD_HIGH);
        send_kind(KIND_FINISH);
        p = '{COORD_LOW, COORD_LOW, COORD_LOW, COORD_HIGH, COORD_LOW, COORD_HIGH,
              COORD_LOW, COORD_HIGH, COORD_HIGH};
        send_item(KIND_TRIANGLE, p);
        p = '{COORD_HIGH, COORD_LOW, COORD_HIGH, COORD_LOW, COORD_HIGH, COORD_LOW,
              COORD_LOW, COORD_LOW, COORD_HIGH};
        send_item(KIND_TRIANGLE, p);
        send_corners(COORD_HIGH, COORD_HIGH, COORD_HIGH);
        send_vertex(coord_t'(-1), coord_t'(-1), coord_t'(-1));
        send_kind(KIND_FINISH);
    endtask

    // Degenerate counting at both extremes of the threshold.
    task automatic test_degenerate_limit();
        write_limit('1);
        send_corners(coord_t'(0), coord_t'(1), coord_t'(2));
        send_corners(coord_t'(0), coord_t'(16), coord_t'(4096));
        send_triangle();
        send_corners(COORD_LOW, COORD_HIGH, coord_t'(0));
        send_kind(KIND_FINISH);
        write_limit('0);
        send_corners(coord_t'(5), coord_t'(5), coord_t'(5));
        send_corners(coord_t'(0), coord_t'(1), coord_t'(-7));
        send_triangle();
        send_kind(KIND_FINISH);
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_backpressure();
        recv_hold = 400;
        no_gaps   = 1'b1;
        for (int n = 0; n < 4; n++)
        begin
            send_vertex(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
            send_triangle();
            send_kind(KIND_FINISH);
        end
        no_gaps = 1'b0;
    endtask

    // Random meshes with random contents, a little noise and fresh thresholds.
    task automatic test_random_meshes(int target);
        int mesh_len;
        int meshes;
        int r;
        meshes = 0;
        while (items_sent < target)
        begin
            no_gaps  = ($urandom_range(0, 4) == 0);
            mesh_len = $urandom_range(0, 20);
            for (int k = 0; k < mesh_len; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    send_vertex(random_coord(), random_coord(), random_coord());
                else if (r < 95)
                    send_triangle();
                else if (r < 98)
                    send_kind(KIND_UNUSED);
                else
                    send_kind(KIND_FINISH);
            end
            send_kind(KIND_FINISH);
            meshes++;
            if (meshes % 15 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       write_limit('0);
                    1:       write_limit('1);
                    default: write_limit(LIMIT_BITS'($urandom_range(0, 4096)));
                endcase
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH report %0d %s: got 0x%0h expected 0x%0h",
                 reports_seen, field, got, want);
        error_count++;
    endtask

    // Receiver readiness: random stalls, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_hold     <= recv_hold - 1;
        end
        else if (recv_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= recv_stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            recv_stall    <= pick_gap();
        end
    end

    // Checks each accepted report against the oldest expectation.
    always @(posedge clk)
    begin
        mesh_stats_t want;
        logic [8*OUT_BYTES-1:0] d;
        int pos;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            d = m_axis_tdata;
            if (expected_stats.size() == 0)
            begin
                $display("UNEXPECTED report with nothing pending");
                error_count++;
            end
            else
            begin
                want = expected_stats.pop_front();
                for (int i = 0; i < 3; i++)
                begin
                    if (d[i*COORD_BITS +: COORD_BITS] !== want.box_min[i])
                        report_mismatch($sformatf("min[%0d]", i),
                                        d[i*COORD_BITS +: COORD_BITS], want.box_min[i]);
                    if (d[(3+i)*COORD_BITS +: COORD_BITS] !== want.box_max[i])
                        report_mismatch($sformatf("max[%0d]", i),
                                        d[(3+i)*COORD_BITS +: COORD_BITS], want.box_max[i]);
                end
                pos = 6 * COORD_BITS;
                if (d[pos +: SUM_BITS] !== want.total)
                    report_mismatch("total_area", d[pos +: SUM_BITS], want.total);
                pos += SUM_BITS;
                if (d[pos +: AREA_BITS] !== want.least)
                    report_mismatch("least_area", d[pos +: AREA_BITS], want.least);
                pos += AREA_BITS;
                if (d[pos +: AREA_BITS] !== want.greatest)
                    report_mismatch("greatest_area", d[pos +: AREA_BITS], want.greatest);
                pos += AREA_BITS;
                if (d[pos +: COUNT_BITS] !== want.vertices)
                    report_mismatch("vertices_seen", d[pos +: COUNT_BITS], want.vertices);
                pos += COUNT_BITS;
                if (d[pos +: COUNT_BITS] !== want.triangles)
                    report_mismatch("triangles_seen", d[pos +: COUNT_BITS], want.triangles);
                pos += COUNT_BITS;
                if (d[pos +: COUNT_BITS] !== want.degenerates)
                    report_mismatch("degenerate_seen", d[pos +: COUNT_BITS], want.degenerates);
            end
            reports_seen++;
        end
    end

    // Ends the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_VERTEX;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        error_count   = 0;
        items_sent    = 0;
        reports_seen  = 0;
        limit_writes  = 0;
        idle_cycles   = 0;
        recv_hold     = 0;
        recv_stall    = 0;
        no_gaps       = 1'b0;
        degenerate_limit = '0;
        clear_stats();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        write_limit('0);
        test_empty_mesh();
        test_extremes();
        test_degenerate_limit();
        test_backpressure();
        write_limit(LIMIT_BITS'(300));
        test_random_meshes(1100);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_stats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d items over empty, extreme, degenerate and random meshes.",
                 items_sent);
        $display("Checked %0d statistics reports across %0d threshold writes.",
                 reports_seen, limit_writes);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
